>>> sv/assert_macros.svh
// Assertion helpers; every check samples on clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/stdp_pkg.sv
package stdp_pkg;

    localparam int ByteW  = 8;
    localparam int DutyW  = 12;
    localparam int CfgIdxW = 2;

    // Register map of the configuration port
    localparam logic [CfgIdxW-1:0] REG_SYNC_BYTE  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CHAN_A_ID  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CHAN_B_ID  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_DECIMATION = 2'd3;

    localparam logic [ByteW-1:0] SYNC_BYTE_RST  = 8'hFF;
    localparam logic [ByteW-1:0] CHAN_A_ID_RST  = 8'h60;
    localparam logic [ByteW-1:0] CHAN_B_ID_RST  = 8'h61;
    localparam logic [ByteW-1:0] DECIMATION_RST = 8'd10;

    typedef struct packed {
        logic [ByteW-1:0] sync_byte;
        logic [ByteW-1:0] chan_a_id;
        logic [ByteW-1:0] chan_b_id;
        logic [ByteW-1:0] decimation;
    } cfg_t;

    typedef struct packed {
        logic             channel;
        logic [DutyW-1:0] duty;
    } res_t;

    // Handshake between the parser core and the two register stages
    typedef struct packed {
        logic take;   // consume the byte held in the input register
        logic push;   // load a new result into the output register
    } flow_t;

endpackage

>>> sv/stdp_byte_if.sv
interface stdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/stdp_duty_if.sv
interface stdp_duty_if;
    logic        valid;
    logic        ready;
    logic        channel;
    logic [11:0] duty;

    modport source (output valid, output channel, output duty, input ready);
    modport sink (input valid, input channel, input duty, output ready);
endinterface

>>> sv/stdp_cfg_regs.sv
module stdp_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stdp_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [stdp_pkg::ByteW-1:0]      cfg_wdata,
    output stdp_pkg::cfg_t                  cfg
);
    import stdp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_BYTE:  cfg_next.sync_byte  = cfg_wdata;
                REG_CHAN_A_ID:  cfg_next.chan_a_id  = cfg_wdata;
                REG_CHAN_B_ID:  cfg_next.chan_b_id  = cfg_wdata;
                REG_DECIMATION: cfg_next.decimation = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte  <= SYNC_BYTE_RST;
            cfg_reg.chan_a_id  <= CHAN_A_ID_RST;
            cfg_reg.chan_b_id  <= CHAN_B_ID_RST;
            cfg_reg.decimation <= DECIMATION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/stdp_in_stage.sv
module stdp_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    stdp_byte_if.sink                   rx,
    input  logic                        take,
    output logic                        byte_vld,
    output logic [stdp_pkg::ByteW-1:0]  byte_data
);
    import stdp_pkg::*;

    logic             vld_reg;
    logic             vld_next;
    logic [ByteW-1:0] byte_reg;
    logic             load;

    // Refill whenever the held byte is empty or leaves this cycle
    assign rx.ready = !vld_reg || take;
    assign load     = rx.valid && rx.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
            vld_next = 1'b1;
        else if (take)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            byte_reg <= rx.rx_byte;
    end

    assign byte_vld  = vld_reg;
    assign byte_data = byte_reg;

endmodule

>>> sv/stdp_frame_core.sv
module stdp_frame_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stdp_pkg::cfg_t              cfg,
    input  logic                        byte_vld,
    input  logic [stdp_pkg::ByteW-1:0]  byte_data,
    input  logic                        out_space,
    output stdp_pkg::flow_t             flow,
    output stdp_pkg::res_t              res
);
    import stdp_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [ByteW-1:0] frame_id_reg;
    logic [ByteW-1:0] low_part_reg;
    logic [ByteW-1:0] count_a_reg, count_a_next;
    logic [ByteW-1:0] count_b_reg, count_b_next;
    logic [ByteW-1:0] count_a_inc, count_b_inc;
    logic             hit_a, hit_b;
    logic             due_a, due_b;
    logic             emit;
    logic             take;

    assign hit_a = (phase_reg == PH_HIGH) && (frame_id_reg == cfg.chan_a_id);
    assign hit_b = (phase_reg == PH_HIGH) && !hit_a && (frame_id_reg == cfg.chan_b_id);

    assign count_a_inc = count_a_reg + 8'd1;
    assign count_b_inc = count_b_reg + 8'd1;
    assign due_a       = count_a_inc >= cfg.decimation;
    assign due_b       = count_b_inc >= cfg.decimation;

    assign emit = (hit_a && due_a) || (hit_b && due_b);
    // Hold the byte only when it would produce a result with nowhere to go
    assign take = byte_vld && (out_space || !emit);

    assign flow.take = take;
    assign flow.push = take && emit;

    assign res.channel = hit_b;
    assign res.duty    = {byte_data, low_part_reg[7:6], 2'b00};

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT: if (byte_data == cfg.sync_byte) phase_next = PH_ID;
            PH_ID:   phase_next = PH_LOW;
            PH_LOW:  phase_next = PH_HIGH;
            PH_HIGH: phase_next = PH_ID;
            default: phase_next = PH_HUNT;
        endcase
    end

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (hit_a)
            count_a_next = due_a ? '0 : count_a_inc;
        if (hit_b)
            count_b_next = due_b ? '0 : count_b_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_a_reg <= '0;
            count_b_reg <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && phase_reg == PH_ID)
            frame_id_reg <= byte_data;
        if (take && phase_reg == PH_LOW)
            low_part_reg <= byte_data;
    end

endmodule

>>> sv/stdp_out_stage.sv
module stdp_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stdp_pkg::res_t  res,
    output logic            out_space,
    stdp_duty_if.source     upd
);
    import stdp_pkg::*;

    logic vld_reg;
    logic vld_next;
    res_t res_reg;

    // Free when empty or when the waiting beat leaves this cycle
    assign out_space = !vld_reg || upd.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (push)
            vld_next = 1'b1;
        else if (upd.ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            res_reg <= res;
    end

    assign upd.valid   = vld_reg;
    assign upd.channel = res_reg.channel;
    assign upd.duty    = res_reg.duty;

endmodule

>>> sv/sync_triplet_duty_parser_top.sv
// Serial frame parser: takes one received byte per beat on rx, drops bytes until the
// sync byte shows up, then reads every following byte triplet as (id, low, high) for
// good, never hunting for sync again. A frame whose id matches channel A (or, failing
// that, channel B) steps that channel's frame counter; when the counter reaches the
// decimation count it clears and one beat leaves on upd with the channel and
// duty = ((high << 2) | (low >> 6)) * 4. Frames with other ids are consumed silently.
// Throughput is one byte per cycle unless a result waits on a stalled upd; each byte
// passes through the input register before it reaches the core, and its result, if
// any, is held in the result register, which drives upd.
// Configuration (sync byte, the two ids, decimation) is written through cfg_we /
// cfg_index / cfg_wdata and must only change while no bytes are in flight.
`include "assert_macros.svh"

module sync_triplet_duty_parser_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stdp_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [stdp_pkg::ByteW-1:0]      cfg_wdata,
    stdp_byte_if.sink                       rx,
    stdp_duty_if.source                     upd
);
    import stdp_pkg::*;

    cfg_t             cfg;
    flow_t            flow;
    res_t             res;
    logic             byte_vld;
    logic [ByteW-1:0] byte_data;
    logic             out_space;

    // Register file for the four settings
    stdp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register: holds one received byte until the core consumes it
    stdp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .take      (flow.take),
        .byte_vld  (byte_vld),
        .byte_data (byte_data)
    );

    // Frame state, channel counters and duty formation
    stdp_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .byte_vld  (byte_vld),
        .byte_data (byte_data),
        .out_space (out_space),
        .flow      (flow),
        .res       (res)
    );

    // Result register: lets the core keep going while a beat waits on upd
    stdp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (flow.push),
        .res       (res),
        .out_space (out_space),
        .upd       (upd)
    );

    // A duty is always the ten-bit value times four
    `ASSERT_IMPLY(a_duty_aligned, upd.valid, upd.duty[1:0] == 2'b00, "duty not a multiple of four")
    // A new result appears only after the core pushed one
    `ASSERT_IMPLY(a_res_from_push, $rose(upd.valid), $past(flow.push), "result without push")
    // A byte the core did not take stays in the input register unchanged
    `ASSERT_NEXT(a_byte_held, byte_vld && !flow.take, byte_vld && $stable(byte_data),
        "input byte lost")
    // Never push into a full result register that is not draining
    `ASSERT_IMPLY(a_no_overrun, flow.push, !upd.valid || upd.ready, "result overrun")

endmodule
